### rtl/sup3_pkg.sv
// Shared types, widths and phase coefficient table for the row upsampler.
`timescale 1ns / 1ps

package sup3_pkg;

  localparam int EXTENT  = 4;
  localparam int DIM     = 2 * EXTENT + 1;
  localparam int FILL_W  = $clog2(DIM + 1);
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int FRAC_W  = 14;
  localparam int PROD_W  = PIX_W + 1 + COEF_W;
  localparam int ACC_W   = PROD_W + $clog2(DIM) + 1;
  localparam int Q_W     = ACC_W - FRAC_W;
  localparam int VAL_W   = 10;
  localparam int PH_W    = 2;
  localparam int VAL_MIN = -256;
  localparam int VAL_MAX = 511;
  localparam int ROUND_BIAS = 1 << (FRAC_W - 1);

  localparam logic [PH_W-1:0] PHASE_0 = 2'd0;
  localparam logic [PH_W-1:0] PHASE_1 = 2'd1;
  localparam logic [PH_W-1:0] PHASE_2 = 2'd2;

  typedef logic [DIM-1:0][PIX_W-1:0] win_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [DIM-1:0] coef_row_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             line_start;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PH_W-1:0]         phase;
    logic                    last;
  } out_t;

  // Q2.14 windowed sinc taps, index 0 is the oldest sample of the line.
  function automatic coef_row_t coef_row(input logic [PH_W-1:0] ph);
    coef_row_t row;
    row = '0;
    case (ph)
      PHASE_1: begin
        row[1] = -16'sd202;
        row[2] = 16'sd985;
        row[3] = -16'sd2942;
        row[4] = 16'sd13786;
        row[5] = 16'sd5883;
        row[6] = -16'sd1379;
        row[7] = 16'sd252;
      end
      PHASE_2: begin
        row[1] = -16'sd193;
        row[2] = 16'sd908;
        row[3] = -16'sd2480;
        row[4] = 16'sd7263;
        row[5] = 16'sd12398;
        row[6] = -16'sd1816;
        row[7] = 16'sd304;
      end
      default: begin
        row[4] = 16'sd16384;
      end
    endcase
    return row;
  endfunction

endpackage

### rtl/sup3_mac.sv
// Dot product of one window with one phase, then rounding and saturation.
`timescale 1ns / 1ps

module sup3_mac (
  input  sup3_pkg::win_t            win,
  input  logic [sup3_pkg::PH_W-1:0] phase,
  output sup3_pkg::out_t            res
);
  import sup3_pkg::*;

  coef_row_t               row;
  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    q;

  always_comb begin
    row = coef_row(phase);
    acc = ACC_W'(ROUND_BIAS);
    for (int i = 0; i < DIM; i++) begin
      prod[i] = PROD_W'($signed({1'b0, win[i]})) * PROD_W'(row[i]);
      acc     = acc + ACC_W'(prod[i]);
    end
    q = acc[ACC_W-1:FRAC_W];
  end

  always_comb begin
    if (q < Q_W'(VAL_MIN)) begin
      res.value = VAL_W'(VAL_MIN);
    end else if (q > Q_W'(VAL_MAX)) begin
      res.value = VAL_W'(VAL_MAX);
    end else begin
      res.value = q[VAL_W-1:0];
    end
    res.phase = phase;
    res.last  = (phase == PHASE_2);
  end

endmodule

### rtl/sinc_row_upsample_by_three.sv
// Top level of the windowed-sinc row upsampler by three.
`timescale 1ns / 1ps

// Each accepted pixel enters a nine-sample delay line; once nine pixels of the
// current row have arrived (counting from the last beat with line_start set),
// the line is captured and three beats follow on the output, one per cycle
// while out_stall is low, at shifts 0, 1/3 and 2/3 of a sample, the last of
// them flagged. The three phases share one nine-tap multiply-accumulate unit,
// and a pixel is taken only while no line is held or as the last phase of the
// held line is loaded to the output. The first result of a line passes through
// the window register and then the output register.
module sinc_row_upsample_by_three (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sup3_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sup3_pkg::out_t out_data
);
  import sup3_pkg::*;

  win_t              dl_r, dl_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  win_t              win_r, win_nxt;
  logic              win_vld_r, win_vld_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  out_t              out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_t              mac_res;
  logic              out_load;
  logic              win_free;
  logic              in_acc;
  logic              win_full;

  sup3_mac u_mac (
    .win   (win_r),
    .phase (phase_r),
    .res   (mac_res)
  );

  assign out_load = win_vld_r && (!out_vld_r || !out_stall);
  assign win_free = !win_vld_r || (out_load && (phase_r == PHASE_2));
  assign in_stall = !win_free;
  assign in_acc   = in_valid && win_free;

  always_comb begin
    dl_nxt   = {in_data.pixel, dl_r[DIM-1:1]};
    fill_nxt = fill_r;
    if (in_data.line_start) begin
      fill_nxt = FILL_W'(1);
    end else if (fill_r < FILL_W'(DIM)) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    win_full = (fill_nxt == FILL_W'(DIM));
  end

  always_comb begin
    win_nxt     = win_r;
    win_vld_nxt = win_vld_r;
    phase_nxt   = phase_r;
    if (in_acc && win_full) begin
      win_nxt     = dl_nxt;
      win_vld_nxt = 1'b1;
      phase_nxt   = PHASE_0;
    end else if (out_load) begin
      if (phase_r == PHASE_2) begin
        win_vld_nxt = 1'b0;
      end else begin
        phase_nxt = phase_r + PH_W'(1);
      end
    end
  end

  always_comb begin
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_nxt     = mac_res;
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r      <= '0;
      fill_r    <= '0;
      win_vld_r <= 1'b0;
      phase_r   <= PHASE_0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        dl_r   <= dl_nxt;
        fill_r <= fill_nxt;
      end
      win_vld_r <= win_vld_nxt;
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### test/tb_sinc_row_upsample_by_three.sv
// Self-checking testbench for the windowed-sinc row upsampler by three.
`timescale 1ns / 1ps

module tb_sinc_row_upsample_by_three;
  import sup3_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    in_t         beat;
    int unsigned gap;
    bit          drain;
  } pixel_item_t;

  localparam u64_t ONE_Q30 = 64'd1073741824;
  localparam u64_t PI_Q30  = 64'd3373259426;
  localparam u64_t K_Q30   = 64'd887977341;
  localparam logic [PH_W-1:0] PHASES [3] = '{PHASE_0, PHASE_1, PHASE_2};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  pixel_item_t pixel_q [$];
  out_t        interp_q [$];
  longint      tap_coef [3][DIM];
  logic [PIX_W-1:0] row_line [DIM];
  int unsigned fill_cnt;
  int unsigned err_cnt;
  int unsigned n_items;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned cyc;
  pixel_item_t staged;
  bit          staged_ok;

  sinc_row_upsample_by_three DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic u64_t taylor_cos(input u64_t x);
    u64_t   term;
    longint acc;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    for (int k = 1; k <= 12; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / u64_t'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    return u64_t'(acc);
  endfunction

  function automatic void build_taps();
    longint tap [DIM];
    longint gain, m, d;
    u64_t   am, ad, x, c, w, mag, q;
    for (int p = 0; p < 3; p++) begin
      gain = 0;
      for (int i = 0; i < DIM; i++) begin
        m  = longint'(i - EXTENT);
        am = (m < 0) ? -m : m;
        x  = PI_Q30 * am / u64_t'(2 * EXTENT);
        c  = taylor_cos(x);
        w  = (c * c) >> 30;
        if (PHASES[p] == PHASE_0) begin
          tap[i] = (m == 0) ? longint'(w) : 0;
        end else begin
          d   = 3 * m - p;
          ad  = (d < 0) ? -d : d;
          mag = ((K_Q30 / ad) * w) >> 30;
          tap[i] = ((am[0] == 1'b0) ? (d < 0) : (d > 0)) ? longint'(mag) : -longint'(mag);
        end
        gain += tap[i];
      end
      if (gain <= 0) gain = longint'(ONE_Q30);
      for (int i = 0; i < DIM; i++) begin
        mag = (tap[i] < 0) ? u64_t'(-tap[i]) : u64_t'(tap[i]);
        q   = (mag * 16384 + u64_t'(gain) / 2) / u64_t'(gain);
        tap_coef[p][i] = (tap[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic void interpolate_beat(input in_t b);
    longint acc, v;
    out_t   r;
    for (int i = 0; i < DIM - 1; i++) row_line[i] = row_line[i + 1];
    row_line[DIM - 1] = b.pixel;
    if (b.line_start) begin
      fill_cnt = 1;
    end else if (fill_cnt < DIM) begin
      fill_cnt++;
    end
    if (fill_cnt < DIM) return;
    for (int p = 0; p < 3; p++) begin
      acc = longint'(ROUND_BIAS);
      for (int i = 0; i < DIM; i++) acc += longint'(row_line[i]) * tap_coef[p][i];
      v = acc >>> FRAC_W;
      if (v < VAL_MIN) v = longint'(VAL_MIN);
      if (v > VAL_MAX) v = longint'(VAL_MAX);
      r.value = v[VAL_W-1:0];
      r.phase = PHASES[p];
      r.last  = (PHASES[p] == PHASE_2);
      interp_q.push_back(r);
    end
  endfunction

  function automatic int unsigned span_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_pixel(input logic [PIX_W-1:0] pix, input bit ls,
                                    input int unsigned gap, input bit drain);
    pixel_item_t it;
    it.beat.pixel      = pix;
    it.beat.line_start = ls;
    it.gap             = gap;
    it.drain           = drain;
    pixel_q.push_back(it);
    n_items++;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned mode);
    case (mode)
      0: return PIX_W'($urandom_range(0, 255));
      1: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      default: return ($urandom_range(0, 1) != 0) ? PIX_W'($urandom_range(240, 255))
                                                  : PIX_W'($urandom_range(0, 15));
    endcase
  endfunction

  // hold the beat until taken; a drain beat waits for every result to arrive
  always @(posedge clk) begin
    logic next_valid;
    in_t  next_data;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      staged_ok = 1'b0;
      gap_left  = 0;
    end else begin
      next_valid = in_valid && in_stall;
      next_data  = in_data;
      if (!next_valid) begin
        if (!staged_ok && pixel_q.size() != 0 &&
            (!pixel_q[0].drain || (!in_valid && interp_q.size() == 0))) begin
          staged    = pixel_q.pop_front();
          gap_left  = staged.gap;
          staged_ok = 1'b1;
        end
        if (staged_ok) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            next_valid = 1'b1;
            next_data  = staged.beat;
            staged_ok  = 1'b0;
          end
        end
      end
      in_valid <= next_valid;
      in_data  <= next_data;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      cyc        = 0;
    end else begin
      if (in_valid && !in_stall) interpolate_beat(in_data);
      if (out_valid && !out_stall) begin
        if (interp_q.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected beat: value %0d phase %0d last %0d",
                     out_data.value, out_data.phase, out_data.last);
          err_cnt++;
        end else begin
          want = interp_q.pop_front();
          if (out_data.value !== want.value || out_data.phase !== want.phase ||
              out_data.last !== want.last) begin
            if (err_cnt < 10)
              $display("mismatch: exp value %0d phase %0d last %0d, got %0d %0d %0d",
                       want.value, want.phase, want.last,
                       out_data.value, out_data.phase, out_data.last);
            err_cnt++;
          end
        end
      end
      cyc++;
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ((cyc / 300) % 4 != 0) stall_left = span_len();
      end
    end
  end

  initial begin
    logic [DIM-1:0] pos_mask;
    logic [DIM-1:0] neg_mask;
    int unsigned    row_len, mode;
    bit             quiet;
    pos_mask = 9'b010110100;
    neg_mask = 9'b001001010;
    err_cnt  = 0;
    n_items  = 0;
    fill_cnt = 0;
    for (int i = 0; i < DIM; i++) row_line[i] = '0;
    build_taps();

    for (int i = 0; i < DIM; i++) add_pixel(pos_mask[i] ? 8'd255 : 8'd0, i == 0, 0, 1'b0);
    for (int i = 0; i < DIM; i++)
      add_pixel(neg_mask[i] ? 8'd255 : 8'd0, i == 0, i % 3, i == 0);
    add_pixel(8'd255, 1'b0, 0, 1'b0);
    add_pixel(8'd255, 1'b0, 0, 1'b0);
    add_pixel(8'd0, 1'b1, 0, 1'b0);
    add_pixel(8'd255, 1'b0, 1, 1'b0);
    add_pixel(8'd170, 1'b0, 0, 1'b0);
    add_pixel(8'd85, 1'b0, 0, 1'b0);

    while (n_items < 160) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 8) : $urandom_range(9, 24);
      mode    = $urandom_range(0, 2);
      quiet   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < row_len; i++)
        add_pixel(pick_pixel(mode), (i == 0) || ($urandom_range(0, 39) == 0),
                  quiet ? 0 : span_len(), (i == 0) && ($urandom_range(0, 7) == 0));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pixel_q.size() != 0 || staged_ok || in_valid || interp_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && interp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/sup3_pkg.sv
rtl/sup3_mac.sv
rtl/sinc_row_upsample_by_three.sv
test/tb_sinc_row_upsample_by_three.sv
